// File: design/r2c_pkg.sv
`default_nettype none

package r2c_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W  = 6;

    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};
    localparam logic [LEN_W-1:0]  ADDR_BITS = LEN_W'(ADDR_W);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // take a new range, order the bounds, clear the level
        logic emit;      // write one prefix into the output register
        logic sel_hi;    // prefix base comes from the high bound
        logic last;      // prefix closes the range
        logic inc_lo;    // move the low bound past its unaligned edge
        logic step;      // trim the high edge, halve both bounds, next level
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bounds_eq;   // low bound equals high bound
        logic lo_odd;      // low edge unaligned at this level
        logic hi_even;     // high edge unaligned at this level
        logic hi_last;     // trimming the high edge empties the range
        logic out_free;    // output register can take a prefix this cycle
    } sts_t;

endpackage

`default_nettype wire

// File: design/range_to_cidr_prefixes_core.sv
`default_nettype none

// Splits an inclusive IPv4 range (bounds in either order) into the smallest
// list of aligned CIDR prefixes that covers it, one output transaction per
// prefix, with last_prefix set on the final one. Prefixes come out bit level
// by bit level from /32 upward, the low-side block before the high-side block
// at each level; the whole address space gives one /0. A range is taken only
// when the block is idle. Each bit level has a low-edge step, then a
// high-edge step with the halving of both bounds; a range closes at the level
// where the bounds meet, or on a high edge whose trim empties the range. The
// output register holds one prefix; while it waits to be taken the controller
// carries on until the next prefix is ready, and then holds.
module range_to_cidr_prefixes_core
    import r2c_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ADDR_W-1:0] range_start,
    input  wire logic [ADDR_W-1:0] range_end,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ADDR_W-1:0]      network_address,
    output logic [LEN_W-1:0]       prefix_length,
    output logic [ADDR_W-1:0]      net_mask,
    output logic                   last_prefix
);

    cmd_t cmd;
    sts_t sts;

    r2c_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    r2c_dpath u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .range_start     (range_start),
        .range_end       (range_end),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .network_address (network_address),
        .prefix_length   (prefix_length),
        .net_mask        (net_mask),
        .last_prefix     (last_prefix)
    );

    // A taken range keeps the input closed while it is split
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a range was taken");

    // The mask has exactly as many ones as the prefix length
    a_mask_matches_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones(net_mask) == prefix_length))
        else $error("net_mask does not match prefix_length");

    // Host bits of the network address are clear
    a_host_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((network_address & ~net_mask) == '0))
        else $error("network_address has host bits set");

    // The prefix length never passes the address width
    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (prefix_length <= ADDR_BITS))
        else $error("prefix_length out of range");

endmodule

`default_nettype wire

// File: design/r2c_ctrl.sv
`default_nettype none

module r2c_ctrl
    import r2c_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LEVEL = 2'd1;
    localparam logic [1:0] ST_HIGH  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Take a range only between ranges
    assign in_stall = (state_reg != ST_IDLE);

    // Sequence the low edge, then the high edge, of each level
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                if (sts.bounds_eq)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (sts.lo_odd)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.inc_lo = 1'b1;
                        state_next = ST_HIGH;
                    end
                end
                else
                begin
                    state_next = ST_HIGH;
                end
            end
            ST_HIGH:
            begin
                if (sts.hi_even)
                begin
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.sel_hi = 1'b1;
                        cmd.last   = sts.hi_last;
                        cmd.step   = 1'b1;
                        state_next = sts.hi_last ? ST_IDLE : ST_LEVEL;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_LEVEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/r2c_dpath.sv
`default_nettype none

module r2c_dpath
    import r2c_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] range_start,
    input  wire logic [ADDR_W-1:0] range_end,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [ADDR_W-1:0]      network_address,
    output logic [LEN_W-1:0]       prefix_length,
    output logic [ADDR_W-1:0]      net_mask,
    output logic                   last_prefix
);

    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [LEN_W-1:0]  level_reg, level_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [ADDR_W-1:0] mask_reg, mask_next;
    logic              last_reg, last_next;
    logic [ADDR_W-1:0] hi_trim;
    logic [ADDR_W-1:0] base_sel;

    // Status for the controller
    assign sts.bounds_eq = (lo_reg == hi_reg);
    assign sts.lo_odd    = lo_reg[0];
    assign sts.hi_even   = !hi_reg[0];
    assign sts.hi_last   = (lo_reg >= hi_reg);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // Drop the high edge address when it is unaligned
    assign hi_trim = hi_reg - {{(ADDR_W-1){1'b0}}, !hi_reg[0]};

    // Advance the bounds
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        level_next = level_reg;
        if (cmd.load)
        begin
            if (range_end < range_start)
            begin
                lo_next = range_end;
                hi_next = range_start;
            end
            else
            begin
                lo_next = range_start;
                hi_next = range_end;
            end
            level_next = '0;
        end
        else if (cmd.inc_lo)
        begin
            lo_next = lo_reg + {{(ADDR_W-1){1'b0}}, 1'b1};
        end
        else if (cmd.step)
        begin
            lo_next    = lo_reg >> 1;
            hi_next    = hi_trim >> 1;
            level_next = level_reg + {{(LEN_W-1){1'b0}}, 1'b1};
        end
    end

    // Build one prefix in the output register
    assign base_sel = cmd.sel_hi ? hi_reg : lo_reg;

    always_comb
    begin
        addr_next      = addr_reg;
        len_next       = len_reg;
        mask_next      = mask_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            addr_next      = base_sel << level_reg;
            len_next       = ADDR_BITS - level_reg;
            mask_next      = ADDR_ONES << level_reg;
            last_next      = cmd.last;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        level_reg <= level_next;
        addr_reg  <= addr_next;
        len_reg   <= len_next;
        mask_reg  <= mask_next;
        last_reg  <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign network_address = addr_reg;
    assign prefix_length   = len_reg;
    assign net_mask        = mask_reg;
    assign last_prefix     = last_reg;

endmodule

`default_nettype wire
